// ----- hw/rtl/erp_ctrl_pkg.sv -----
// Package: codes, constants, ramp tables and shared types for the relief controller.
`timescale 1ns / 1ps
package erp_ctrl_pkg;

  localparam int CYCLE_TICKS   = 100;
  localparam int TRIGGER_TICKS = 70;

  localparam logic [7:0] RATIO_LIMIT_RESET = 8'd77;

  localparam logic [1:0] REG_RELIEF_LEVEL = 2'd0;
  localparam logic [1:0] REG_RATIO_LIMIT  = 2'd1;

  localparam logic [10:0] GAIN_BASE = 11'd1229;
  localparam logic [10:0] GAIN_MID  = 11'd1226;
  localparam logic [10:0] GAIN_HIGH = 11'd1442;
  localparam logic [10:0] GAIN_TOP  = 11'd1966;
  localparam logic [10:0] GAIN_LOW  = 11'd614;

  localparam logic [16:0] DECAY_SLOW = 17'd59299;
  localparam logic [16:0] DECAY_FAST = 17'd56407;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_FIN
  } seq_state_t;

  typedef enum logic [1:0] {
    PH_LIMIT,
    PH_CYCLE,
    PH_EXHALE,
    PH_TRIGGER
  } phase_t;

  typedef struct packed {
    logic               start;
    logic signed [17:0] a;
    logic signed [17:0] b;
  } mul_req_t;

  typedef logic [16:0] ramp_rom_t [0:127];

  function automatic ramp_rom_t build_ramp(input logic [16:0] c);
    ramp_rom_t   rom;
    logic [33:0] e;
    e = 34'd65536;
    for (int i = 0; i < 128; i++) begin
      rom[i] = e[16:0];
      e = ((e * {17'd0, c}) + 34'd32768) >> 16;
    end
    return rom;
  endfunction

  localparam ramp_rom_t RAMP_SLOW = build_ramp(DECAY_SLOW);
  localparam ramp_rom_t RAMP_FAST = build_ramp(DECAY_FAST);

endpackage

// ----- hw/rtl/erp_in_if.sv -----
// Interface: input tick channel of the relief controller.
`timescale 1ns / 1ps
interface erp_in_if;
  logic               valid;
  logic               ready;
  logic [8:0]         treatment_pressure;
  logic signed [14:0] flow;
  logic signed [14:0] rough_baseline;
  logic signed [14:0] breath_baseline;
  logic [9:0]         breath_rate;

  modport source (output valid, treatment_pressure, flow, rough_baseline,
                  breath_baseline, breath_rate, input ready);
  modport sink (input valid, treatment_pressure, flow, rough_baseline,
                breath_baseline, breath_rate, output ready);
endinterface

// ----- hw/rtl/erp_out_if.sv -----
// Interface: result channel of the relief controller.
`timescale 1ns / 1ps
interface erp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pressure_offset;
  logic [1:0]         relief_phase;

  modport source (output valid, pressure_offset, relief_phase, input ready);
  modport sink (input valid, pressure_offset, relief_phase, output ready);
endinterface

// ----- hw/rtl/erp_cfg_if.sv -----
// Interface: configuration write channel of the relief controller.
`timescale 1ns / 1ps
interface erp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/erp_mul.sv -----
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
module erp_mul
  import erp_ctrl_pkg::*;
(
  input  logic               clk,
  input  mul_req_t           req,
  output logic signed [35:0] prod
);

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= req.a * req.b;
    end
  end

endmodule

// ----- hw/rtl/expiratory_pressure_relief_ctrl.sv -----
// Top level: expiratory pressure relief controller with swing mode and relief machine.
//
// One tick enters on in_ch as a beat carrying treatment pressure, flow, the two
// flow baselines and the breath rate. Each tick gives exactly one result beat on
// out_ch with the signed pressure offset and the relief phase after the tick.
// A tick goes through capture, one pass through the shared multiplier,
// and the finishing step that applies the offset, saturation and state update.
// The multiplier handles the swing gain, the flow ratio cross product and the
// ramp scaling in turn, so only one tick is in work at a time.
// A new tick is accepted only once the last one has left the finishing step.
// A finished result sits in an output register; the next tick is accepted
// while it waits. If the receiver stalls, the finishing step holds until the
// output register frees, and in_ch stays not ready meanwhile.
// cfg takes register writes whenever reset is low: index 0 is relief_level,
// index 1 is the flow ratio limit; other indexes are ignored. Writes are meant
// for idle periods. During reset neither in_ch nor cfg is ready.
// Synchronous reset clears the relief machine to limit phase with zero
// counters and peak flow, sets relief_level to 0 and the ratio limit to 77.
`timescale 1ns / 1ps
module expiratory_pressure_relief_ctrl
  import erp_ctrl_pkg::*;
(
  input logic    clk,
  input logic    rst,
  erp_in_if.sink    in_ch,
  erp_out_if.source out_ch,
  erp_cfg_if.sink   cfg
);

  seq_state_t state, state_next;

  logic [2:0] relief_level;
  logic [7:0] ratio_limit;

  phase_t             phase, phase_next;
  logic [6:0]         cycle_count, cycle_count_next;
  logic [6:0]         trigger_count, trigger_count_next;
  logic signed [14:0] peak_flow, peak_flow_next;

  logic [8:0]         p_r;
  logic signed [14:0] flow_r;
  logic signed [14:0] rough_r;
  logic signed [14:0] bb_r;
  logic [9:0]         rate_r;

  logic               out_valid;
  logic signed [15:0] off_o;
  logic [1:0]         phase_o;

  mul_req_t           mreq;
  logic signed [35:0] prod;

  logic signed [15:0] diff_sw;
  logic signed [15:0] dfb;
  logic signed [15:0] den;
  logic signed [14:0] peak_new;
  logic [10:0]        gain;
  logic [6:0]         lvl10;
  logic signed [10:0] t_room;
  logic signed [10:0] d11;
  logic signed [7:0]  d;
  logic [6:0]         ramp_idx;
  logic [16:0]        ramp_e;
  logic [16:0]        ramp_val;
  logic signed [43:0] off_w;
  logic signed [43:0] pr6;
  logic signed [35:0] num;
  logic               hit;
  logic signed [19:0] dfb20;
  logic signed [19:0] five;
  logic signed [19:0] thr;
  logic               trig;
  logic [6:0]         cnt_inc;
  logic signed [15:0] off_sat;
  logic               load;

  erp_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  assign cfg.ready   = !rst;
  assign in_ch.ready = (state == S_IDLE) && !rst;

  assign out_ch.valid           = out_valid;
  assign out_ch.pressure_offset = off_o;
  assign out_ch.relief_phase    = phase_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      relief_level <= 3'd0;
      ratio_limit  <= RATIO_LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_RELIEF_LEVEL: relief_level <= cfg.data[2:0];
        REG_RATIO_LIMIT:  ratio_limit  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      p_r     <= in_ch.treatment_pressure;
      flow_r  <= in_ch.flow;
      rough_r <= in_ch.rough_baseline;
      bb_r    <= in_ch.breath_baseline;
      rate_r  <= in_ch.breath_rate;
    end
  end

  always_comb begin
    diff_sw  = 16'(flow_r) - 16'(rough_r);
    dfb      = 16'(flow_r) - 16'(bb_r);
    peak_new = (flow_r > peak_flow) ? flow_r : peak_flow;
    den      = 16'(peak_new) - 16'(bb_r);

    gain = GAIN_BASE;
    if (rate_r >= 10'd224 && rate_r < 10'd288) begin
      if (p_r <= 9'd60) gain = GAIN_BASE;
      else if (p_r < 9'd90) gain = GAIN_MID;
      else if (p_r < 9'd140) gain = GAIN_HIGH;
      else if (p_r < 9'd180) gain = GAIN_BASE;
      else gain = GAIN_TOP;
    end else if (rate_r >= 10'd288) begin
      gain = (p_r <= 9'd60) ? GAIN_LOW : GAIN_BASE;
    end

    lvl10  = {1'b0, relief_level, 3'b000} + {3'b000, relief_level, 1'b0};
    t_room = $signed({2'b00, p_r}) - $signed({4'b0000, lvl10});
    if (t_room < 11'sd40) d11 = $signed({2'b00, p_r}) - 11'sd40;
    else d11 = $signed({4'b0000, lvl10});
    d = d11[7:0];

    ramp_idx = (phase == PH_CYCLE) ? cycle_count : trigger_count;
    ramp_e   = (d >= 8'sd25) ? RAMP_SLOW[ramp_idx] : RAMP_FAST[ramp_idx];
    ramp_val = (phase == PH_CYCLE) ? (17'h10000 - ramp_e) : ramp_e;

    mreq.start = (state == S_MUL);
    if (relief_level == 3'd0) begin
      mreq.a = 18'(diff_sw);
      mreq.b = $signed({7'd0, gain});
    end else if (phase == PH_LIMIT) begin
      mreq.a = $signed({10'd0, ratio_limit});
      mreq.b = 18'(den);
    end else begin
      mreq.a = 18'(d);
      mreq.b = $signed({1'b0, ramp_val});
    end
  end

  always_comb begin
    num   = $signed({{12{dfb[15]}}, dfb, 8'd0});
    if (den > 16'sd0) hit = (num <= prod);
    else if (den < 16'sd0) hit = (num >= prod);
    else hit = dfb[15];

    dfb20 = 20'(dfb);
    five  = (dfb20 <<< 2) + dfb20;
    thr   = 20'sd2240 + $signed({8'd0, p_r, 3'b000});
    trig  = (five > thr);

    pr6     = $signed({{2{prod[35]}}, prod, 6'd0});
    cnt_inc = (phase == PH_CYCLE) ? cycle_count + 7'd1 : trigger_count + 7'd1;

    phase_next         = phase;
    cycle_count_next   = cycle_count;
    trigger_count_next = trigger_count;
    peak_flow_next     = peak_flow;
    off_w              = 44'sd0;

    if (relief_level == 3'd0) begin
      off_w = (44'(prod) + 44'sd32768) >>> 16;
    end else if (d != 8'sd0) begin
      case (phase)
        PH_LIMIT: begin
          peak_flow_next = peak_new;
          if (hit) begin
            cycle_count_next = 7'd0;
            phase_next       = PH_CYCLE;
          end
        end
        PH_CYCLE: begin
          off_w = -((pr6 + 44'sd32768) >>> 16);
          if (cnt_inc >= 7'(CYCLE_TICKS)) begin
            phase_next       = PH_EXHALE;
            cycle_count_next = 7'd0;
          end else begin
            cycle_count_next = cnt_inc;
          end
        end
        PH_EXHALE: begin
          off_w = -$signed({{30{d[7]}}, d, 6'd0});
          if (trig) begin
            phase_next         = PH_TRIGGER;
            trigger_count_next = 7'd0;
            peak_flow_next     = flow_r;
          end
        end
        default: begin
          off_w              = -((pr6 + 44'sd32768) >>> 16);
          trigger_count_next = cnt_inc;
          if (cnt_inc >= 7'(TRIGGER_TICKS)) phase_next = PH_LIMIT;
          peak_flow_next = peak_new;
        end
      endcase
    end

    if (off_w > 44'sd32767) off_sat = 16'sh7fff;
    else if (off_w < -44'sd32768) off_sat = -16'sh8000;
    else off_sat = off_w[15:0];
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    case (state)
      S_IDLE: if (in_ch.valid) state_next = S_MUL;
      S_MUL:  state_next = S_FIN;
      S_FIN: begin
        if (!out_valid || out_ch.ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LIMIT;
      cycle_count   <= 7'd0;
      trigger_count <= 7'd0;
      peak_flow     <= 15'sd0;
    end else if (load) begin
      phase         <= phase_next;
      cycle_count   <= cycle_count_next;
      trigger_count <= trigger_count_next;
      peak_flow     <= peak_flow_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      off_o   <= off_sat;
      phase_o <= phase_next;
    end
  end

  a_phase_only_on_load: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(phase))
    else $error("relief phase changed outside the finishing step");

  a_cycle_bound: assert property (@(posedge clk) disable iff (rst)
    cycle_count < 7'(CYCLE_TICKS))
    else $error("cycle counter out of range");

  a_trigger_bound: assert property (@(posedge clk) disable iff (rst)
    trigger_count <= 7'(TRIGGER_TICKS))
    else $error("trigger counter out of range");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == S_MUL))
    else $error("accepted beat did not start the multiplier pass");

endmodule

// ----- verif/tb_expiratory_pressure_relief_ctrl.sv -----
// Testbench for the expiratory pressure relief controller: directed and random ticks.
`timescale 1ns / 1ps
module tb_expiratory_pressure_relief_ctrl;
  import erp_ctrl_pkg::*;

  typedef struct {
    logic signed [15:0] offset;
    logic [1:0]         phase;
  } relief_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  erp_in_if  in_ch();
  erp_out_if out_ch();
  erp_cfg_if cfg();

  expiratory_pressure_relief_ctrl dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  always #10 clk = ~clk;

  relief_out_t expected_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;

  logic [2:0]         m_level = 3'd0;
  logic [7:0]         m_bound = 8'd77;
  phase_t             m_phase = PH_LIMIT;
  logic [6:0]         m_cycle_cnt = '0;
  logic [6:0]         m_trig_cnt = '0;
  logic signed [14:0] m_peak = '0;

  function automatic longint round_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint ramp_value(longint c, int n);
    longint e;
    e = 65536;
    for (int i = 0; i < n; i++) e = (e * c + 32768) >>> 16;
    return e;
  endfunction

  task automatic predict_relief(input logic [8:0] pres, input logic signed [14:0] fl,
                                input logic signed [14:0] rough,
                                input logic signed [14:0] bb, input logic [9:0] rate);
    longint      p, f, b, d, c, off, g, num, den;
    bit          hit;
    relief_out_t r;
    p = pres; f = fl; b = bb; off = 0;
    if (m_level == 0) begin
      g = 1229;
      if (rate >= 224 && rate < 288) begin
        if (p <= 60) g = 1229;
        else if (p < 90) g = 1226;
        else if (p < 140) g = 1442;
        else if (p < 180) g = 1229;
        else g = 1966;
      end else if (rate >= 288) begin
        g = (p <= 60) ? 614 : 1229;
      end
      off = round_q16((f - longint'(rough)) * g);
    end else begin
      d = longint'(m_level) * 10;
      if (p - d < 40) d = p - 40;
      c = (d >= 25) ? 59299 : 56407;
      if (d != 0) begin
        case (m_phase)
          PH_LIMIT: begin
            if (fl > m_peak) m_peak = fl;
            num = (f - b) * 256;
            den = longint'(m_peak) - b;
            if (den > 0) hit = num <= longint'(m_bound) * den;
            else if (den < 0) hit = num >= longint'(m_bound) * den;
            else hit = num < 0;
            if (hit) begin
              m_cycle_cnt = '0;
              m_phase = PH_CYCLE;
            end
          end
          PH_CYCLE: begin
            off = -round_q16(d * 64 * (65536 - ramp_value(c, m_cycle_cnt)));
            m_cycle_cnt = m_cycle_cnt + 7'd1;
            if (m_cycle_cnt >= CYCLE_TICKS) begin
              m_phase = PH_EXHALE;
              m_cycle_cnt = '0;
            end
          end
          PH_EXHALE: begin
            off = -d * 64;
            if (5 * f > 5 * b + 2240 + 8 * p) begin
              m_phase = PH_TRIGGER;
              m_trig_cnt = '0;
              m_peak = fl;
            end
          end
          default: begin
            off = -round_q16(d * 64 * ramp_value(c, m_trig_cnt));
            m_trig_cnt = m_trig_cnt + 7'd1;
            if (m_trig_cnt >= TRIGGER_TICKS) m_phase = PH_LIMIT;
            if (fl > m_peak) m_peak = fl;
          end
        endcase
      end
    end
    if (off > 32767) off = 32767;
    if (off < -32768) off = -32768;
    r.offset = off[15:0];
    r.phase = m_phase;
    expected_q.push_back(r);
  endtask

  task automatic send_tick(input logic [8:0] pres, input logic signed [14:0] fl,
                           input logic signed [14:0] rough,
                           input logic signed [14:0] bb, input logic [9:0] rate);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.treatment_pressure <= pres;
    in_ch.flow <= fl;
    in_ch.rough_baseline <= rough;
    in_ch.breath_baseline <= bb;
    in_ch.breath_rate <= rate;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_relief(pres, fl, rough, bb, rate);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == REG_RELIEF_LEVEL) m_level = val[2:0];
    else if (idx == REG_RATIO_LIMIT) m_bound = val;
    @(posedge clk);
  endtask

  task automatic random_tick();
    logic signed [14:0] bb;
    logic [8:0]         pres;
    bb = 15'($signed($urandom_range(0, 1200)) - 600);
    pres = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(20, 200));
    case ($urandom_range(5))
      0: send_tick(pres, 15'($urandom), 15'($urandom), 15'($urandom), 10'($urandom));
      1: send_tick(pres, bb + 15'($urandom_range(1500, 4000)), 15'($urandom), bb,
                   10'($urandom));
      2: send_tick(pres, bb - 15'($urandom_range(0, 800)), 15'($urandom), bb,
                   10'($urandom));
      default: send_tick(pres, bb + 15'($signed($urandom_range(0, 3000)) - 1000),
                         15'($urandom), bb, 10'($urandom_range(150, 350)));
    endcase
  endtask

  task automatic test_swing_mode();
    write_reg(REG_RELIEF_LEVEL, 8'd0);
    send_tick(9'd0, 15'sh3FFF, 15'sh4000, 15'sd0, 10'd0);
    send_tick(9'd511, 15'sh4000, 15'sh3FFF, 15'sd0, 10'd1023);
    send_tick(9'd60, 15'sd1000, 15'sd0, 15'sd0, 10'd300);
    send_tick(9'd61, 15'sd1000, 15'sd0, 15'sd0, 10'd224);
    send_tick(9'd90, 15'sd1000, 15'sd0, 15'sd0, 10'd287);
    send_tick(9'd140, 15'sd1000, 15'sd0, 15'sd0, 10'd250);
    send_tick(9'd180, -15'sd1000, 15'sd0, 15'sd0, 10'd250);
    send_tick(9'd89, 15'sd7, 15'sd0, 15'sd0, 10'd223);
    drain_results();
  endtask

  task automatic test_relief_cycle();
    write_reg(REG_RELIEF_LEVEL, 8'd7);
    write_reg(REG_RATIO_LIMIT, 8'd255);
    send_tick(9'd40, 15'sd100, 15'sd0, 15'sd0, 10'd100);
    send_tick(9'd20, 15'sd100, 15'sd0, 15'sd0, 10'd100);
    send_tick(9'd100, 15'sd0, 15'sd0, 15'sd0, 10'd100);
    send_tick(9'd100, -15'sd5, 15'sd0, 15'sd0, 10'd100);
    for (int i = 0; i < 102; i++) send_tick(9'd100, 15'sd0, 15'sd0, 15'sd0, 10'd0);
    send_tick(9'd100, 15'sd700, 15'sd0, 15'sd0, 10'd0);
    send_tick(9'd100, 15'sd609, 15'sd0, 15'sd0, 10'd0);
    for (int i = 0; i < 72; i++) send_tick(9'd62, 15'sd200, 15'sd0, 15'sd0, 10'd0);
    drain_results();
    write_reg(REG_RATIO_LIMIT, 8'd0);
    send_tick(9'd100, 15'sh4000, 15'sd0, 15'sh3FFF, 10'd0);
    drain_results();
  endtask

  task automatic test_random_phases();
    int idle_set[4] = '{0, 79, 0, 33};
    int stall_set[4] = '{0, 0, 79, 33};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      write_reg(REG_RELIEF_LEVEL, 8'($urandom_range(0, 7)));
      write_reg(REG_RATIO_LIMIT, (ph == 0) ? 8'd255 : 8'($urandom));
      for (int i = 0; i < 120; i++) random_tick();
      drain_results();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_reg(REG_RELIEF_LEVEL, 8'd3);
    hold_cycles = 200;
    for (int i = 0; i < 50; i++) random_tick();
    drain_results();
    write_reg(REG_RELIEF_LEVEL, 8'd1);
    for (int i = 0; i < 50; i++) random_tick();
    drain_results();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    relief_out_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %0d/%0d",
                                       out_ch.pressure_offset, out_ch.relief_phase);
      end else begin
        e = expected_q.pop_front();
        if (out_ch.pressure_offset !== e.offset || out_ch.relief_phase !== e.phase) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: offset exp %0d got %0d, phase exp %0d got %0d",
                     e.offset, out_ch.pressure_offset, e.phase, out_ch.relief_phase);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.treatment_pressure = '0;
    in_ch.flow = '0;
    in_ch.rough_baseline = '0;
    in_ch.breath_baseline = '0;
    in_ch.breath_rate = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_swing_mode();
    test_relief_cycle();
    test_random_phases();
    test_backpressure();
    drain_results();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
